[sv/adc_pkg.sv]
package adc_pkg;

  // Default fraction width of the wheel speed outputs
  localparam int SPEED_FRAC_BITS_DEF = 16;

  // Configuration port geometry and register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_DIAMETER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEELBASE      = 2'd1;

  localparam logic [9:0]  DIAM_RESET = 10'd65;
  localparam logic [10:0] BASE_RESET = 11'd200;

  // round(pi * 2^24)
  localparam logic [25:0] PI_Q24 = 26'd52707179;

  localparam logic [9:0] SERVO_MID = 10'd500;
  localparam logic [9:0] SERVO_MIN = 10'd375;
  localparam logic [9:0] SERVO_MAX = 10'd625;

  typedef struct packed {
    logic signed [15:0] forward_speed;
    logic signed [15:0] turn_radius;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] motor_one_speed;
    logic signed [31:0] motor_two_speed;
    logic [9:0]         servo_position;
  } res_t;

  // round(tan(k deg) * 2^20) for whole degrees
  function automatic logic [19:0] tan_q20(input logic [4:0] deg);
    logic [19:0] t;
    unique case (deg)
      5'd0:  t = 20'd0;
      5'd1:  t = 20'd18303;
      5'd2:  t = 20'd36617;
      5'd3:  t = 20'd54954;
      5'd4:  t = 20'd73324;
      5'd5:  t = 20'd91739;
      5'd6:  t = 20'd110210;
      5'd7:  t = 20'd128749;
      5'd8:  t = 20'd147368;
      5'd9:  t = 20'd166078;
      5'd10: t = 20'd184892;
      5'd11: t = 20'd203823;
      5'd12: t = 20'd222882;
      5'd13: t = 20'd242083;
      5'd14: t = 20'd261439;
      5'd15: t = 20'd280965;
      5'd16: t = 20'd300674;
      5'd17: t = 20'd320582;
      5'd18: t = 20'd340703;
      5'd19: t = 20'd361054;
      5'd20: t = 20'd381650;
      5'd21: t = 20'd402511;
      5'd22: t = 20'd423652;
      5'd23: t = 20'd445094;
      5'd24: t = 20'd466856;
      5'd25: t = 20'd488959;
      5'd26: t = 20'd511425;
      5'd27: t = 20'd534276;
      5'd28: t = 20'd557538;
      5'd29: t = 20'd581235;
      5'd30: t = 20'd605396;
      5'd31: t = 20'd630048;
    endcase
    return t;
  endfunction

endpackage

[sv/adc_ifs.sv]
interface adc_cmd_if;
  import adc_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface adc_res_if;
  import adc_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[sv/adc_div_pipe.sv]
module adc_div_pipe #(
  parameter int NW = 20,
  parameter int DW = 17,
  parameter int QW = 7,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [NW-1:0] rem,
  output logic [SW-1:0] side_out
);
  // Compare width wide enough for the divisor shifted to the top quotient bit
  localparam int EW = (NW > DW + QW) ? NW : DW + QW;

  logic [QW-1:0] vld_r;
  logic [NW-1:0] acc_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  // One restoring step per stage, most significant quotient bit first
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vin;
    logic [NW-1:0] ain;
    logic [QW-1:0] qin;
    logic [DW-1:0] din;
    logic [SW-1:0] sin;
    logic [EW-1:0] a_ext;
    logic [EW-1:0] trial;
    logic          ge;
    logic [NW-1:0] acc_nxt;
    logic [QW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign ain = num;
      assign qin = '0;
      assign din = den;
      assign sin = side_in;
    end else begin : g_next
      assign vin = vld_r[k-1];
      assign ain = acc_r[k-1];
      assign qin = quo_r[k-1];
      assign din = den_r[k-1];
      assign sin = side_r[k-1];
    end

    assign a_ext   = EW'(ain);
    assign trial   = EW'(din) << (QW - 1 - k);
    assign ge      = (a_ext >= trial);
    assign acc_nxt = ge ? NW'(a_ext - trial) : ain;
    assign quo_nxt = qin | (QW'(ge) << (QW - 1 - k));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k]  <= acc_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= din;
        side_r[k] <= sin;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign quo       = quo_r[QW-1];
  assign rem       = acc_r[QW-1];
  assign side_out  = side_r[QW-1];

endmodule

[sv/ackermann_drive_command_core.sv]
// Channel   Dir  Handshake     Payload
// in_cmd    in   valid/ready   forward_speed, turn_radius
// out_res   out  valid/ready   motor_one_speed, motor_two_speed, servo_position
// cfg_*     in   cfg_we only   cfg_index, cfg_wdata
//
// One request enters per cycle unless the output stalls; the pipe is made up of
// three bit-per-stage dividers: servo offset (7), wheel speed (F+14) and
// outer wheel correction (F+24), plus seven plain register stages.
// Reset is synchronous, active low; it clears the valid bits and the configuration registers.
// A stall at the output freezes the whole pipe; in_cmd.ready is low only then.
module ackermann_drive_command_core #(
  parameter int SPEED_FRAC_BITS = adc_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  adc_cmd_if.sink                       in_cmd,
  adc_res_if.source                     out_res,
  input  logic                          cfg_we,
  input  logic [adc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import adc_pkg::*;

  localparam int F   = SPEED_FRAC_BITS;
  localparam int M1W = F + 14;   // inner wheel speed magnitude
  localparam int NAW = 16 + F + 24;
  localparam int PW  = F + 24;   // speed times diameter, correction term
  localparam int P2W = F + 44;
  localparam int M2W = F + 25;

  typedef struct packed {
    logic [15:0] mag;
    logic        sneg;
    logic        nside;
    logic        rnz;
    logic        clamp;
  } sb_t;

  typedef struct packed {
    logic       sneg;
    logic       nside;
    logic [9:0] servo;
    logic [4:0] angle;
  } sa_t;

  typedef struct packed {
    logic [M1W-1:0] m1;
    logic           sneg;
    logic           nside;
    logic [9:0]     servo;
    logic           tz;
  } sc_t;

  localparam int SBW = $bits(sb_t);
  localparam int SAW = $bits(sa_t);
  localparam int SCW = $bits(sc_t);

  // Saturate a sign and magnitude to signed 32 bits
  function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [31:0] res;
    if (!neg) begin
      res = (mag > 64'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
    end else begin
      res = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag[31:0]);
    end
    return res;
  endfunction

  logic [9:0]  diam_r;
  logic [10:0] base_r;
  logic        en;

  logic               v0_r;
  logic signed [15:0] vx_r;
  logic signed [15:0] rad_r;

  logic [15:0] mag_nxt;
  logic [15:0] rabs_nxt;
  logic [21:0] ll_sq;
  logic        v1_r;
  logic [15:0] mag1_r;
  logic        sneg1_r;
  logic        nside1_r;
  logic [15:0] rabs1_r;
  logic [31:0] rr1_r;
  logic [23:0] ll3_1_r;
  logic [19:0] num1_r;
  sb_t         sb_in;

  logic        vb;
  logic [6:0]  qb;
  logic [19:0] remb;
  logic [SBW-1:0] sb_raw;
  sb_t         sbo;

  logic signed [9:0]  off;
  logic [7:0]         ceil_q;
  logic signed [10:0] srv;
  logic signed [10:0] srv_c;
  logic signed [10:0] sdiff;
  logic [7:0]         adiff;
  logic        v2_r;
  logic [15:0] mag2_r;
  logic        sneg2_r;
  logic        nside2_r;
  logic [9:0]  servo2_r;
  logic [4:0]  angle2_r;
  logic [35:0] diva2_r;
  sa_t         sa_in;

  logic           va;
  logic [M1W-1:0] qa;
  logic [SAW-1:0] sa_raw;
  sa_t            sao;

  logic [M1W-1:0] m1_nxt;
  logic           v3_r;
  logic [M1W-1:0] m1_3_r;
  logic [19:0]    t3_r;
  logic [9:0]     servo3_r;
  logic           sneg3_r;
  logic           nside3_r;

  logic           v4_r;
  logic [PW-1:0]  p1_4_r;
  logic [M1W-1:0] m1_4_r;
  logic [19:0]    t4_r;
  logic [9:0]     servo4_r;
  logic           sneg4_r;
  logic           nside4_r;

  logic [P2W-1:0] p2;
  logic           v5_r;
  logic [PW-1:0]  n5_r;
  logic           tz5_r;
  logic [M1W-1:0] m1_5_r;
  logic [9:0]     servo5_r;
  logic           sneg5_r;
  logic           nside5_r;
  sc_t            sc_in;

  logic           vc;
  logic [PW-1:0]  qc;
  logic [SCW-1:0] sc_raw;
  sc_t            sco;

  logic [PW-1:0]  term;
  logic [M2W-1:0] m2;
  logic [31:0]    one_nxt;
  logic [31:0]    two_nxt;
  logic           out_valid_r;
  res_t           res_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diam_r <= DIAM_RESET;
      base_r <= BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHEEL_DIAMETER: diam_r <= cfg_wdata[9:0];
        CFG_WHEELBASE:      base_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole pipe advances unless the output holds an untaken result
  assign en           = !out_valid_r || out_res.ready;
  assign in_cmd.ready = en;

  // Stage 0: capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r  <= in_cmd.data.forward_speed;
      rad_r <= in_cmd.data.turn_radius;
    end
  end

  // Stage 1: magnitudes and squares for the steering clamp
  assign mag_nxt  = vx_r[15] ? 16'(-vx_r) : vx_r;
  assign rabs_nxt = rad_r[15] ? 16'(-rad_r) : rad_r;
  assign ll_sq    = 22'(base_r) * 22'(base_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r   <= mag_nxt;
      sneg1_r  <= vx_r[15];
      nside1_r <= rad_r[15];
      rabs1_r  <= rabs_nxt;
      rr1_r    <= 32'(rabs_nxt) * 32'(rabs_nxt);
      ll3_1_r  <= 24'(ll_sq) * 24'd3;
      num1_r   <= 20'(base_r) * 20'd375;
    end
  end

  assign sb_in.mag   = mag1_r;
  assign sb_in.sneg  = sneg1_r;
  assign sb_in.nside = nside1_r;
  assign sb_in.rnz   = (rabs1_r != 16'd0);
  assign sb_in.clamp = ({8'd0, ll3_1_r} > rr1_r);

  // Servo offset: 375*L / (2*|radius|)
  adc_div_pipe #(.NW(20), .DW(17), .QW(7), .SW(SBW)) u_div_servo (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v1_r),
    .num      (num1_r),
    .den      ({rabs1_r, 1'b0}),
    .side_in  (sb_in),
    .out_valid(vb),
    .quo      (qb),
    .rem      (remb),
    .side_out (sb_raw)
  );
  assign sbo = sb_t'(sb_raw);

  // Stage 2: servo position and steering angle
  always_comb begin
    ceil_q = {1'b0, qb} + {7'd0, (remb != 20'd0)};
    priority if (!sbo.rnz || base_r == 11'd0) begin
      off = 10'sd0;
    end else if (sbo.clamp) begin
      off = sbo.nside ? -10'sd109 : 10'sd108;
    end else if (sbo.nside) begin
      off = -$signed({2'b00, ceil_q});
    end else begin
      off = $signed({3'b000, qb});
    end
    srv = $signed({1'b0, SERVO_MID}) + 11'(off);
    priority if (srv > $signed({1'b0, SERVO_MAX})) begin
      srv_c = $signed({1'b0, SERVO_MAX});
    end else if (srv < $signed({1'b0, SERVO_MIN})) begin
      srv_c = $signed({1'b0, SERVO_MIN});
    end else begin
      srv_c = srv;
    end
    sdiff = srv_c - $signed({1'b0, SERVO_MID});
    adiff = sdiff[10] ? 8'(-sdiff) : 8'(sdiff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2_r   <= sbo.mag;
      sneg2_r  <= sbo.sneg;
      nside2_r <= sbo.nside;
      servo2_r <= srv_c[9:0];
      angle2_r <= adiff[6:2];
      diva2_r  <= 36'(PI_Q24) * 36'(diam_r);
    end
  end

  assign sa_in.sneg  = sneg2_r;
  assign sa_in.nside = nside2_r;
  assign sa_in.servo = servo2_r;
  assign sa_in.angle = angle2_r;

  // Inner wheel speed: |speed| * 2^(F+24) / (pi * D)
  adc_div_pipe #(.NW(NAW), .DW(36), .QW(M1W), .SW(SAW)) u_div_speed (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v2_r),
    .num      ({mag2_r, {(F + 24){1'b0}}}),
    .den      (diva2_r),
    .side_in  (sa_in),
    .out_valid(va),
    .quo      (qa),
    .rem      (),
    .side_out (sa_raw)
  );
  assign sao = sa_t'(sa_raw);

  // Stage 3: drop steering when the wheel speed is zero
  assign m1_nxt = (diam_r == 10'd0) ? '0 : qa;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_3_r   <= m1_nxt;
      t3_r     <= (m1_nxt != '0) ? tan_q20(sao.angle) : 20'd0;
      servo3_r <= (m1_nxt != '0) ? sao.servo : SERVO_MID;
      sneg3_r  <= sao.sneg;
      nside3_r <= sao.nside;
    end
  end

  // Stage 4: speed times diameter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_4_r   <= PW'(m1_3_r) * PW'(diam_r);
      m1_4_r   <= m1_3_r;
      t4_r     <= t3_r;
      servo4_r <= servo3_r;
      sneg4_r  <= sneg3_r;
      nside4_r <= nside3_r;
    end
  end

  // Stage 5: times tan, drop the table fraction
  assign p2 = P2W'(p1_4_r) * P2W'(t4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n5_r     <= p2[P2W-1:20];
      tz5_r    <= (t4_r == 20'd0) || (base_r == 11'd0);
      m1_5_r   <= m1_4_r;
      servo5_r <= servo4_r;
      sneg5_r  <= sneg4_r;
      nside5_r <= nside4_r;
    end
  end

  assign sc_in.m1    = m1_5_r;
  assign sc_in.sneg  = sneg5_r;
  assign sc_in.nside = nside5_r;
  assign sc_in.servo = servo5_r;
  assign sc_in.tz    = tz5_r;

  // Outer wheel correction: |v1| * D * tan / (L * 2^20)
  adc_div_pipe #(.NW(PW), .DW(11), .QW(PW), .SW(SCW)) u_div_outer (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v5_r),
    .num      (n5_r),
    .den      (base_r),
    .side_in  (sc_in),
    .out_valid(vc),
    .quo      (qc),
    .rem      (),
    .side_out (sc_raw)
  );
  assign sco = sc_t'(sc_raw);

  // Stage 6: pick sides and saturate
  always_comb begin
    term = sco.tz ? '0 : qc;
    m2   = M2W'(sco.m1) + M2W'(term);
    if (sco.nside) begin
      one_nxt = sat_mag(sco.sneg, 64'(sco.m1));
      two_nxt = sat_mag(!sco.sneg, 64'(m2));
    end else begin
      one_nxt = sat_mag(!sco.sneg, 64'(m2));
      two_nxt = sat_mag(sco.sneg, 64'(sco.m1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.motor_one_speed <= one_nxt;
      res_r.motor_two_speed <= two_nxt;
      res_r.servo_position  <= sco.servo;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = res_r;

`ifndef NO_ASSERTIONS
  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.servo_position >= SERVO_MIN &&
                     res_r.servo_position <= SERVO_MAX))
    else $error("servo position out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |=> (out_valid_r && $stable(res_r)))
    else $error("result changed while stalled");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(v5_r) && $stable(n5_r) && $stable(v2_r)))
    else $error("pipe moved while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !v0_r))
    else $error("valid bits not cleared by reset");
`endif

endmodule

[tb/ackermann_drive_command_core_tb.sv]
`timescale 1ns / 100ps

module ackermann_drive_command_core_tb;
  import adc_pkg::*;

  localparam int FRAC       = SPEED_FRAC_BITS_DEF;
  localparam int PIPE_DEPTH = 2 * FRAC + 52;
  localparam int STALL_MAX  = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int unsigned TAN_DEG_Q20 [32] = '{
    0, 18303, 36617, 54954, 73324, 91739, 110210, 128749,
    147368, 166078, 184892, 203823, 222882, 242083, 261439, 280965,
    300674, 320582, 340703, 361054, 381650, 402511, 423652, 445094,
    466856, 488959, 511425, 534276, 557538, 581235, 605396, 630048
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  adc_cmd_if in_cmd();
  adc_res_if out_res();

  ackermann_drive_command_core dut (
    .clk(clk), .rst_n(rst_n), .in_cmd(in_cmd), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copies of the geometry registers
  logic [9:0]  diam_mm = DIAM_RESET;
  logic [10:0] base_mm = BASE_RESET;

  res_t pending_drive[$];
  int   errors = 0;
  bit   quiet = 1'b0;
  int   hold_cycles = 0;
  int   idle_count = 0;

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Compute servo and motor speeds for one drive request
  function automatic res_t predict_drive(cmd_t c);
    res_t r;
    longint unsigned mag, rabs, num, den, term, tq, lsq;
    longint v1, v2, off, servo, diff;
    int unsigned angle;
    mag = (c.forward_speed < 0) ? -longint'(c.forward_speed) : c.forward_speed;
    rabs = (c.turn_radius < 0) ? -longint'(c.turn_radius) : c.turn_radius;
    v1 = 0;
    servo = SERVO_MID;
    if (diam_mm != 0) begin
      num = (mag << (FRAC + 24)) / (longint'(PI_Q24) * diam_mm);
      v1 = (c.forward_speed < 0) ? -longint'(num) : longint'(num);
    end
    v2 = v1;
    if (v1 != 0) begin
      if (rabs != 0 && base_mm != 0) begin
        lsq = 3 * longint'(base_mm) * base_mm;
        if (lsq > rabs * rabs) begin
          off = (c.turn_radius < 0) ? -109 : 108;
        end else begin
          num = 375 * longint'(base_mm);
          den = 2 * rabs;
          off = (c.turn_radius < 0) ? -longint'((num + den - 1) / den) : longint'(num / den);
        end
        servo = SERVO_MID + off;
        if (servo > SERVO_MAX) servo = SERVO_MAX;
        if (servo < SERVO_MIN) servo = SERVO_MIN;
      end
      diff = servo - SERVO_MID;
      angle = 32'(((diff < 0) ? -diff : diff) / 4);
      tq = TAN_DEG_Q20[angle & 31];
      if (tq != 0 && base_mm != 0) begin
        mag = (v1 < 0) ? -v1 : v1;
        term = (mag * diam_mm * tq) / (longint'(base_mm) << 20);
        v2 = (v1 < 0) ? v1 - longint'(term) : v1 + longint'(term);
      end
    end
    if (c.turn_radius < 0) begin
      r.motor_one_speed = clip32(v1);
      r.motor_two_speed = clip32(-v2);
    end else begin
      r.motor_one_speed = clip32(-v2);
      r.motor_two_speed = clip32(v1);
    end
    r.servo_position = servo[9:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Offer one request, with random idle cycles ahead of it unless quiet is set
  task automatic send_drive(logic signed [15:0] speed, logic signed [15:0] radius);
    cmd_t c;
    c.forward_speed = speed;
    c.turn_radius = radius;
    while (!quiet && $urandom_range(99) < 22) begin
      in_cmd.valid <= 1'b0;
      @(posedge clk);
    end
    in_cmd.valid <= 1'b1;
    in_cmd.data <= c;
    do @(posedge clk); while (!in_cmd.ready);
    pending_drive.push_back(predict_drive(c));
  endtask

  // Drop valid and let the pipe empty out
  task automatic drain_pipe();
    in_cmd.valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
  endtask

  // Pulse the write enable for one cycle, then drop it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WHEEL_DIAMETER) diam_mm = val[9:0];
    else if (idx == CFG_WHEELBASE) base_mm = val;
    @(posedge clk);
  endtask

  task automatic set_geometry(int d, int l);
    drain_pipe();
    write_reg(CFG_WHEEL_DIAMETER, CFG_DATA_W'(d));
    write_reg(CFG_WHEELBASE, CFG_DATA_W'(l));
  endtask

  function automatic logic signed [15:0] pick_radius();
    case ($urandom_range(9))
      0: return 16'sd0;
      1, 2: return 16'(int'($urandom_range(600)) - 300);
      3, 4: return 16'(int'($urandom_range(8000)) - 4000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_speed();
    case ($urandom_range(9))
      0: return 16'sd0;
      1: return 16'(int'($urandom_range(20)) - 10);
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [15:0] speeds [6] = '{16'sd0, 16'sd1, -16'sd1, 16'sh7fff, 16'sh8000,
                                       16'sd500};
    logic signed [15:0] radii [4] = '{16'sd0, 16'sd100, -16'sd100, 16'sh7fff};
    foreach (speeds[i]) foreach (radii[j]) send_drive(speeds[i], radii[j]);
    send_drive(16'sd300, 16'sh8000);
    send_drive(-16'sd300, 16'sd1);
    send_drive(16'sd1000, -16'sd1);
  endtask

  task automatic test_random_phase(int count);
    repeat (count) send_drive(pick_speed(), pick_radius());
  endtask

  task automatic test_geometry_sweep();
    set_geometry(1, 1);
    test_random_phase(170);
    set_geometry(1000, 2000);
    test_random_phase(170);
    set_geometry(1, 2000);
    test_random_phase(170);
    set_geometry(1000, 1);
    test_random_phase(150);
    set_geometry($urandom_range(1000, 1), $urandom_range(2000, 1));
    quiet = 1'b1;
    test_random_phase(150);
    quiet = 1'b0;
    // writes to an unused index must leave the geometry alone
    drain_pipe();
    write_reg(CFG_UNUSED, 11'h7ff);
    test_random_phase(100);
  endtask

  task automatic test_backpressure();
    set_geometry(int'(DIAM_RESET), int'(BASE_RESET));
    hold_cycles = 300;
    test_random_phase(120);
  endtask

  // Check each result against the oldest expectation, then pick next ready
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        if (pending_drive.size() == 0) begin
          report_mismatch("unexpected result count", 1, 0);
        end else begin
          want = pending_drive.pop_front();
          if (out_res.data.motor_one_speed !== want.motor_one_speed)
            report_mismatch("motor_one_speed", out_res.data.motor_one_speed,
                            want.motor_one_speed);
          if (out_res.data.motor_two_speed !== want.motor_two_speed)
            report_mismatch("motor_two_speed", out_res.data.motor_two_speed,
                            want.motor_two_speed);
          if (out_res.data.servo_position !== want.servo_position)
            report_mismatch("servo_position", out_res.data.servo_position,
                            want.servo_position);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= quiet || ($urandom_range(99) >= 22);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_cmd.valid && in_cmd.ready) || (out_res.valid && out_res.ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= STALL_MAX) begin
      $display("ackermann_drive_command_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_WHEEL_DIAMETER;
    cfg_wdata <= '0;
    in_cmd.valid <= 1'b0;
    in_cmd.data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(100);
    test_geometry_sweep();
    test_backpressure();
    drain_pipe();
    if (errors == 0) begin
      $display("ackermann_drive_command_core_tb: done, clean");
    end else begin
      $display("ackermann_drive_command_core_tb: done, errors");
    end
    $finish;
  end

endmodule
